// ===== hw/rtl/lhos_pkg.sv =====
package lhos_pkg;

    localparam int LAYER_W       = 6;
    localparam int SUPER_W       = 4;
    localparam int AXIAL_IDX_W   = 3;
    localparam int MIN_HITS_W    = 8;
    localparam int LAYER_COUNT_W = 6;
    localparam int SUPER_MASK_W  = 9;
    localparam int SUPER_COUNT_W = 4;
    localparam int GAP_W         = 2;
    localparam int TOTAL_W       = 8;

    localparam logic [MIN_HITS_W-1:0] MIN_HITS_RESET = 8'd1;
    localparam logic [TOTAL_W-1:0]    TOTAL_MAX      = 8'd255;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_OUT
    } t_state;

endpackage

// ===== hw/rtl/layer_hit_occupancy_summary_unit.sv =====
// A hit without the last mark is accumulated and busy stays low.
// A hit with the last mark starts a scan over max(layers, superlayers, axial superlayers)
// entries (one entry per cycle; layers, superlayers and axial superlayers each go through
// their own count/compare logic), then ST_OUT gives the result with a one-cycle strobe;
// no new hit is accepted until the scan and output are done. The receiver cannot stall.
// Synchronous active-low reset clears all accumulated state; min_hits resets to 1.
module layer_hit_occupancy_summary_unit #(
    parameter int NUM_LAYERS             = 56,
    parameter int NUM_SUPER_LAYERS       = 9,
    parameter int NUM_AXIAL_SUPER_LAYERS = 5,
    parameter int COUNT_WIDTH            = 8
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [lhos_pkg::LAYER_W-1:0]         i_layer_index,
    input  logic [lhos_pkg::SUPER_W-1:0]         i_super_layer_index,
    input  logic [lhos_pkg::AXIAL_IDX_W-1:0]     i_axial_super_index,
    input  logic                                 i_is_axial,
    input  logic                                 i_last,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [lhos_pkg::MIN_HITS_W-1:0]      i_cfg_data,
    output logic                                 o_strobe,
    output logic [lhos_pkg::LAYER_COUNT_W-1:0]   o_layer_count,
    output logic [lhos_pkg::SUPER_MASK_W-1:0]    o_super_mask,
    output logic [lhos_pkg::SUPER_COUNT_W-1:0]   o_super_count,
    output logic [lhos_pkg::SUPER_MASK_W-1:0]    o_super_mask_min,
    output logic [lhos_pkg::SUPER_COUNT_W-1:0]   o_super_count_min,
    output logic [lhos_pkg::GAP_W-1:0]           o_max_axial_gap,
    output logic [lhos_pkg::TOTAL_W-1:0]         o_axial_total,
    output logic [lhos_pkg::TOTAL_W-1:0]         o_stereo_total
);

    localparam int NL = NUM_LAYERS;
    localparam int NS = NUM_SUPER_LAYERS;
    localparam int NA = NUM_AXIAL_SUPER_LAYERS;
    localparam int L_A = (NL > NS) ? NL : NS;
    localparam int L = (L_A > NA) ? L_A : NA;
    localparam int IDX_W = (L > 1) ? $clog2(L) : 1;
    localparam int LW = (NL > 1) ? $clog2(NL) : 1;
    localparam int SW = (NS > 1) ? $clog2(NS) : 1;
    localparam int AW = (NA > 1) ? $clog2(NA) : 1;
    localparam int LCW_R = $clog2(NL + 1);
    localparam int LCW = (LCW_R > lhos_pkg::LAYER_COUNT_W + 1) ? LCW_R
                                                               : lhos_pkg::LAYER_COUNT_W + 1;
    localparam int SCW_R = $clog2(NS + 1);
    localparam int SCW = (SCW_R > lhos_pkg::SUPER_COUNT_W + 1) ? SCW_R
                                                               : lhos_pkg::SUPER_COUNT_W + 1;
    localparam int RW_R = $clog2(NA + 1);
    localparam int RW = (RW_R > lhos_pkg::GAP_W + 1) ? RW_R : lhos_pkg::GAP_W + 1;
    localparam int CMP_W = (COUNT_WIDTH > lhos_pkg::MIN_HITS_W) ? COUNT_WIDTH
                                                                 : lhos_pkg::MIN_HITS_W;
    localparam int LAYER_CMP_W = (LW + 1 > lhos_pkg::LAYER_W + 1) ? LW + 1
                                                                  : lhos_pkg::LAYER_W + 1;
    localparam int SUPER_CMP_W = (SW + 1 > lhos_pkg::SUPER_W + 1) ? SW + 1
                                                                  : lhos_pkg::SUPER_W + 1;
    localparam int AXIAL_CMP_W = (AW + 1 > lhos_pkg::AXIAL_IDX_W + 1) ? AW + 1
                                                                      : lhos_pkg::AXIAL_IDX_W + 1;

    lhos_pkg::t_state r_state, n_state;

    logic [lhos_pkg::MIN_HITS_W-1:0] r_min_hits, n_min_hits;
    logic [NL-1:0]                   r_layers, n_layers;
    logic [COUNT_WIDTH-1:0]          r_cnt [NS];
    logic [COUNT_WIDTH-1:0]          n_cnt [NS];
    logic [NA-1:0]                   r_axial_seen, n_axial_seen;
    logic [lhos_pkg::TOTAL_W-1:0]    r_axial_hits, n_axial_hits;
    logic [lhos_pkg::TOTAL_W-1:0]    r_stereo_hits, n_stereo_hits;

    logic [IDX_W-1:0] r_idx, n_idx;
    logic [LCW-1:0]   r_lcount, n_lcount;
    logic [SCW-1:0]   r_scount, n_scount;
    logic [SCW-1:0]   r_smcount, n_smcount;
    logic [NS-1:0]    r_smask, n_smask;
    logic [NS-1:0]    r_smmask, n_smmask;
    logic             r_started, n_started;
    logic [RW-1:0]    r_run, n_run;
    logic [RW-1:0]    r_gap, n_gap;

    logic accept;
    logic in_layer, in_super, in_axial;
    logic [SW-1:0] sl_sel;
    logic sc_layer, sc_super, sc_axial;
    logic sl_hit, sl_min;

    assign busy        = (r_state != lhos_pkg::ST_IDLE);
    assign accept      = start && !busy;
    assign o_cfg_ready = 1'b1;

    assign in_layer = (LAYER_CMP_W'(i_layer_index) < LAYER_CMP_W'(NL));
    assign in_super = (SUPER_CMP_W'(i_super_layer_index) < SUPER_CMP_W'(NS));
    assign in_axial = (AXIAL_CMP_W'(i_axial_super_index) < AXIAL_CMP_W'(NA));
    assign sl_sel   = SW'(i_super_layer_index);

    assign sc_layer = ({1'b0, r_idx} < (IDX_W + 1)'(NL));
    assign sc_super = ({1'b0, r_idx} < (IDX_W + 1)'(NS));
    assign sc_axial = ({1'b0, r_idx} < (IDX_W + 1)'(NA));
    assign sl_hit   = (r_cnt[0] != '0);
    assign sl_min   = (CMP_W'(r_cnt[0]) >= CMP_W'(r_min_hits));

    always_comb begin
        n_state       = r_state;
        n_min_hits    = r_min_hits;
        n_layers      = r_layers;
        n_cnt         = r_cnt;
        n_axial_seen  = r_axial_seen;
        n_axial_hits  = r_axial_hits;
        n_stereo_hits = r_stereo_hits;
        n_idx         = r_idx;
        n_lcount      = r_lcount;
        n_scount      = r_scount;
        n_smcount     = r_smcount;
        n_smask       = r_smask;
        n_smmask      = r_smmask;
        n_started     = r_started;
        n_run         = r_run;
        n_gap         = r_gap;
        o_strobe      = 1'b0;

        if (i_cfg_valid) begin
            n_min_hits = i_cfg_data;
        end

        unique case (r_state)
            lhos_pkg::ST_IDLE: begin
                if (accept) begin
                    if (in_layer) begin
                        n_layers[LW'(i_layer_index)] = 1'b1;
                    end
                    if (in_super && (r_cnt[sl_sel] != '1)) begin
                        n_cnt[sl_sel] = r_cnt[sl_sel] + 1'b1;
                    end
                    if (i_is_axial) begin
                        if (in_axial) begin
                            n_axial_seen[AW'(i_axial_super_index)] = 1'b1;
                        end
                        if (r_axial_hits != lhos_pkg::TOTAL_MAX) begin
                            n_axial_hits = r_axial_hits + 1'b1;
                        end
                    end else if (r_stereo_hits != lhos_pkg::TOTAL_MAX) begin
                        n_stereo_hits = r_stereo_hits + 1'b1;
                    end
                    if (i_last) begin
                        n_idx   = '0;
                        n_state = lhos_pkg::ST_SCAN;
                    end
                end
            end
            lhos_pkg::ST_SCAN: begin
                if (sc_layer) begin
                    if (r_layers[0]) begin
                        n_lcount = r_lcount + 1'b1;
                    end
                    n_layers = r_layers >> 1;
                end
                if (sc_super) begin
                    if (sl_hit) begin
                        n_scount = r_scount + 1'b1;
                    end
                    if (sl_min) begin
                        n_smcount = r_smcount + 1'b1;
                    end
                    n_smask  = NS'({sl_hit, r_smask} >> 1);
                    n_smmask = NS'({sl_min, r_smmask} >> 1);
                    for (int k = 0; k < NS - 1; k++) begin
                        n_cnt[k] = r_cnt[k + 1];
                    end
                    n_cnt[NS-1] = '0;
                end
                if (sc_axial) begin
                    if (r_axial_seen[0]) begin
                        if (r_started && (r_run > r_gap)) begin
                            n_gap = r_run;
                        end
                        n_started = 1'b1;
                        n_run     = '0;
                    end else if (r_started) begin
                        n_run = r_run + 1'b1;
                    end
                    n_axial_seen = r_axial_seen >> 1;
                end
                if (r_idx == IDX_W'(L - 1)) begin
                    n_state = lhos_pkg::ST_OUT;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            lhos_pkg::ST_OUT: begin
                o_strobe      = 1'b1;
                n_layers      = '0;
                n_axial_seen  = '0;
                n_axial_hits  = '0;
                n_stereo_hits = '0;
                n_lcount      = '0;
                n_scount      = '0;
                n_smcount     = '0;
                n_smask       = '0;
                n_smmask      = '0;
                n_started     = 1'b0;
                n_run         = '0;
                n_gap         = '0;
                for (int k = 0; k < NS; k++) begin
                    n_cnt[k] = '0;
                end
                n_state = lhos_pkg::ST_IDLE;
            end
            default: begin
                n_state = lhos_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_layer_count     = (r_lcount > LCW'(63)) ? 6'd63
                                                  : lhos_pkg::LAYER_COUNT_W'(r_lcount);
        o_super_mask      = lhos_pkg::SUPER_MASK_W'(r_smask);
        o_super_count     = (r_scount > SCW'(15)) ? 4'd15
                                                  : lhos_pkg::SUPER_COUNT_W'(r_scount);
        o_super_mask_min  = lhos_pkg::SUPER_MASK_W'(r_smmask);
        o_super_count_min = (r_smcount > SCW'(15)) ? 4'd15
                                                   : lhos_pkg::SUPER_COUNT_W'(r_smcount);
        o_max_axial_gap   = (r_gap > RW'(3)) ? 2'd3 : lhos_pkg::GAP_W'(r_gap);
        o_axial_total     = r_axial_hits;
        o_stereo_total    = r_stereo_hits;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= lhos_pkg::ST_IDLE;
            r_min_hits    <= lhos_pkg::MIN_HITS_RESET;
            r_layers      <= '0;
            r_axial_seen  <= '0;
            r_axial_hits  <= '0;
            r_stereo_hits <= '0;
            r_idx         <= '0;
            r_lcount      <= '0;
            r_scount      <= '0;
            r_smcount     <= '0;
            r_smask       <= '0;
            r_smmask      <= '0;
            r_started     <= 1'b0;
            r_run         <= '0;
            r_gap         <= '0;
            for (int k = 0; k < NS; k++) begin
                r_cnt[k] <= '0;
            end
        end else begin
            r_state       <= n_state;
            r_min_hits    <= n_min_hits;
            r_layers      <= n_layers;
            r_axial_seen  <= n_axial_seen;
            r_axial_hits  <= n_axial_hits;
            r_stereo_hits <= n_stereo_hits;
            r_idx         <= n_idx;
            r_lcount      <= n_lcount;
            r_scount      <= n_scount;
            r_smcount     <= n_smcount;
            r_smask       <= n_smask;
            r_smmask      <= n_smmask;
            r_started     <= n_started;
            r_run         <= n_run;
            r_gap         <= n_gap;
            r_cnt         <= n_cnt;
        end
    end

endmodule
